// ===== rtl/core/fldc_pkg.sv =====
package fldc_pkg;

  localparam logic [7:0] START_BYTE   = 8'h7E;
  localparam logic [8:0] LEN_OVERHEAD = 9'd2;
  localparam logic [8:0] MIN_FRAME    = 9'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FRAME_LEN  = 3'd0,
    REG_SETTINGS_TYPE  = 3'd1,
    REG_CONFIGURATION  = 3'd2,
    REG_SETTINGS04     = 3'd3,
    REG_FILTER_CYCLES  = 3'd4,
    REG_INFORMATION    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CONFIG     = 3'd0,
    KIND_SETTINGS04 = 3'd1,
    KIND_FILTER     = 3'd2,
    KIND_INFO       = 3'd3,
    KIND_UNKNOWN    = 3'd4,
    KIND_OTHER      = 3'd5
  } kind_t;

  typedef enum logic {
    ACT_FORWARD = 1'b0,
    ACT_CACHE   = 1'b1
  } action_t;

  typedef struct packed {
    logic [8:0] max_frame_len;
    logic [7:0] settings_type_code;
    logic [7:0] configuration_code;
    logic [7:0] settings04_code;
    logic [7:0] filter_cycles_code;
    logic [7:0] information_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
    logic [3:0] fresh_mask;
  } rx_word_t;

  typedef struct packed {
    action_t    action;
    kind_t      kind;
    logic [8:0] frame_len;
    logic [7:0] type_byte;
    logic [7:0] subtype_byte;
  } verdict_t;

endpackage

// ===== rtl/core/fldc_stream_if.sv =====
interface fldc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fldc_cfg_regs.sv =====
module fldc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fldc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fldc_pkg::CFG_DATA_W-1:0] cfg_data,
  output fldc_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_frame_len      <= 9'd128;
      cfg.settings_type_code <= 8'd34;
      cfg.configuration_code <= 8'd0;
      cfg.settings04_code    <= 8'd4;
      cfg.filter_cycles_code <= 8'd1;
      cfg.information_code   <= 8'd2;
    end else if (cfg_we) begin
      unique case (fldc_pkg::reg_idx_t'(cfg_index))
        fldc_pkg::REG_MAX_FRAME_LEN: cfg.max_frame_len      <= cfg_data;
        fldc_pkg::REG_SETTINGS_TYPE: cfg.settings_type_code <= cfg_data[7:0];
        fldc_pkg::REG_CONFIGURATION: cfg.configuration_code <= cfg_data[7:0];
        fldc_pkg::REG_SETTINGS04:    cfg.settings04_code    <= cfg_data[7:0];
        fldc_pkg::REG_FILTER_CYCLES: cfg.filter_cycles_code <= cfg_data[7:0];
        fldc_pkg::REG_INFORMATION:   cfg.information_code   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/fldc_in_stage.sv =====
module fldc_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  fldc_stream_if.sink          rx,
  input  logic                 advance,
  output logic                 word_valid,
  output fldc_pkg::rx_word_t   word
);

  // holds one word; takes a new one when empty or whenever the held word moves on
  assign rx.ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (rx.ready) begin
      word_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      word <= rx.data;
    end
  end

endmodule

// ===== rtl/core/fldc_deframer.sv =====
module fldc_deframer (
  input  logic               clk,
  input  logic               rst,
  input  fldc_pkg::cfg_t     cfg,
  input  logic               word_valid,
  input  fldc_pkg::rx_word_t word,
  output logic               advance,
  fldc_stream_if.source      verdict
);

  fldc_pkg::phase_t phase, phase_next;
  logic [8:0] byte_index, byte_index_next;
  logic [8:0] frame_length, frame_length_next;
  logic [7:0] captured_type, captured_type_next;
  logic [7:0] captured_subtype, captured_subtype_next;

  logic [8:0]        len;
  logic [8:0]        index_inc;
  logic              done;
  fldc_pkg::kind_t   kind;
  fldc_pkg::action_t action;

  assign advance   = word_valid && (!verdict.valid || verdict.ready);
  assign len       = {1'b0, word.rx_byte} + fldc_pkg::LEN_OVERHEAD;
  assign index_inc = byte_index + 9'd1;

  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    frame_length_next     = frame_length;
    captured_type_next    = captured_type;
    captured_subtype_next = captured_subtype;
    unique case (phase)
      fldc_pkg::PH_LEN: begin
        if (len < fldc_pkg::MIN_FRAME || len > cfg.max_frame_len) begin
          phase_next = (word.rx_byte == fldc_pkg::START_BYTE) ?
                       fldc_pkg::PH_LEN : fldc_pkg::PH_HUNT;
        end else begin
          frame_length_next = len;
          byte_index_next   = 9'd2;
          phase_next        = fldc_pkg::PH_BODY;
        end
      end
      fldc_pkg::PH_BODY: begin
        if (byte_index == 9'd4) captured_type_next = word.rx_byte;
        if (byte_index == 9'd5) captured_subtype_next = word.rx_byte;
        byte_index_next = index_inc;
        if (index_inc >= frame_length) phase_next = fldc_pkg::PH_HUNT;
      end
      default: begin
        phase_next = (word.rx_byte == fldc_pkg::START_BYTE) ?
                     fldc_pkg::PH_LEN : fldc_pkg::PH_HUNT;
      end
    endcase
    if (word.end_of_buffer) phase_next = fldc_pkg::PH_HUNT;
  end

  always_comb begin
    done = (phase == fldc_pkg::PH_BODY) && (index_inc >= frame_length);
    priority if (captured_type_next != cfg.settings_type_code) begin
      kind = fldc_pkg::KIND_OTHER;
    end else if (captured_subtype_next == cfg.configuration_code) begin
      kind = fldc_pkg::KIND_CONFIG;
    end else if (captured_subtype_next == cfg.settings04_code) begin
      kind = fldc_pkg::KIND_SETTINGS04;
    end else if (captured_subtype_next == cfg.filter_cycles_code) begin
      kind = fldc_pkg::KIND_FILTER;
    end else if (captured_subtype_next == cfg.information_code) begin
      kind = fldc_pkg::KIND_INFO;
    end else begin
      kind = fldc_pkg::KIND_UNKNOWN;
    end
    unique case (kind)
      fldc_pkg::KIND_CONFIG:     action = fldc_pkg::action_t'(word.fresh_mask[0]);
      fldc_pkg::KIND_SETTINGS04: action = fldc_pkg::action_t'(word.fresh_mask[1]);
      fldc_pkg::KIND_FILTER:     action = fldc_pkg::action_t'(word.fresh_mask[2]);
      fldc_pkg::KIND_INFO:       action = fldc_pkg::action_t'(word.fresh_mask[3]);
      default:                   action = fldc_pkg::ACT_FORWARD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= fldc_pkg::PH_HUNT;
      byte_index       <= 9'd0;
      frame_length     <= 9'd0;
      captured_type    <= 8'd0;
      captured_subtype <= 8'd0;
    end else if (advance) begin
      phase            <= phase_next;
      byte_index       <= byte_index_next;
      frame_length     <= frame_length_next;
      captured_type    <= captured_type_next;
      captured_subtype <= captured_subtype_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (advance) begin
      verdict.valid <= done;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      verdict.data.action       <= action;
      verdict.data.kind         <= kind;
      verdict.data.frame_len    <= frame_length;
      verdict.data.type_byte    <= captured_type_next;
      verdict.data.subtype_byte <= captured_subtype_next;
    end
  end

endmodule

// ===== rtl/core/flag_length_deframer_classifier.sv =====
// Flag/length deframer with request classifier.
// rx carries one received byte per word, with an end-of-buffer mark and the
// cache freshness mask. The block hunts for a 0x7E start byte, reads the
// length byte (frame length = L+2, accepted from 6 to max_frame_len), then
// counts frame bytes, keeping bytes 4 and 5. On the last byte of a frame one
// word goes out on verdict: kind, cache/forward action, length, type, subtype.
// Bytes that complete no frame produce no verdict word.
// Verdict path: the byte lands in the input register, then the deframer state
// updates and the verdict register loads from it.
// Throughput: one byte per cycle while no verdict word is held; the per-byte
// state update is a single compare-and-count step.
// Stall: a held verdict word stops the deframer; rx takes one more byte only
// if the input register is empty, then ready drops until the verdict is taken.
// Reset: synchronous; hunting for a start byte, both registers empty, config
// registers at their defaults. Config writes (cfg_we/cfg_index/cfg_data) take
// effect at the next edge and are meant for idle periods.
module flag_length_deframer_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fldc_pkg::CFG_DATA_W-1:0] cfg_data,
  fldc_stream_if.sink                     rx,
  fldc_stream_if.source                   verdict
);

  fldc_pkg::cfg_t     cfg;
  fldc_pkg::rx_word_t word;
  logic               word_valid;
  logic               advance;

  fldc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fldc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  fldc_deframer u_deframer (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .word_valid (word_valid),
    .word       (word),
    .advance    (advance),
    .verdict    (verdict)
  );

endmodule
